>>> rtl/aoc_pkg.sv
// ----------------------------------------------------------------------------
// aoc_pkg: shared types and constants for the box clip near/far block
// Coordinate types, triangle packing and the fixed box triangle table.
// ----------------------------------------------------------------------------
`default_nettype none

package aoc_pkg;

  localparam int COORD_W     = 32;
  localparam int BOX_TRIS    = 12;
  localparam int CLIP_PLANES = 4;
  localparam int TRI_W       = 9 * COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [2:0]                corner_idx_t;
  // vertex: [0] x, [1] y, [2] z
  typedef logic [2:0][COORD_W-1:0]      vert_t;
  // triangle: three vertices
  typedef logic [2:0][2:0][COORD_W-1:0] tri_t;

  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  // corner indexes of the 12 box triangles, three per triangle
  localparam corner_idx_t BOX_CORNER [BOX_TRIS*3] = '{
    3'd0, 3'd1, 3'd2, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd5, 3'd6, 3'd7,
    3'd0, 3'd2, 3'd4, 3'd2, 3'd4, 3'd6, 3'd1, 3'd3, 3'd5, 3'd3, 3'd5, 3'd7,
    3'd0, 3'd1, 3'd4, 3'd1, 3'd4, 3'd5, 3'd2, 3'd3, 3'd6, 3'd3, 3'd6, 3'd7
  };

endpackage

`default_nettype wire

>>> rtl/aoc_if.sv
// ----------------------------------------------------------------------------
// aoc_if: request channels of the box clip near/far block
// Corner request channel and near/far result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface aoc_in_if import aoc_pkg::*; ();
  logic        valid;
  logic        ready;
  corner_idx_t corner_index;
  coord_t      corner_x;
  coord_t      corner_y;
  coord_t      corner_z;
  coord_t      window_min_x;
  coord_t      window_max_x;
  coord_t      window_min_y;
  coord_t      window_max_y;

  modport source (
    output valid, corner_index, corner_x, corner_y, corner_z,
           window_min_x, window_max_x, window_min_y, window_max_y,
    input  ready
  );
  modport sink (
    input  valid, corner_index, corner_x, corner_y, corner_z,
           window_min_x, window_max_x, window_min_y, window_max_y,
    output ready
  );
endinterface

interface aoc_out_if import aoc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t near_z;
  coord_t far_z;
  logic   nothing_survived;

  modport source (output valid, near_z, far_z, nothing_survived, input ready);
  modport sink   (input  valid, near_z, far_z, nothing_survived, output ready);
endinterface

`default_nettype wire

>>> rtl/aoc_ram.sv
// ----------------------------------------------------------------------------
// aoc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aoc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/aabb_ortho_clip_near_far_top.sv
// ----------------------------------------------------------------------------
// aabb_ortho_clip_near_far_top: near/far depth of a light-space box clipped
// to an orthographic x/y window.
// ----------------------------------------------------------------------------
// Corners 0..6 are only stored, with no result. Corner 7 starts the clip run.
// A crossing point runs on the shared unit (set-up, FRACTION_BITS+1 divide
// steps, 3 x 3 scale/add steps). in_chan.ready is low for the whole run.
// Reset (rst_n low, synchronous) idles the sequencer, clears flags, count, the
// result valid flag and the running min/max; corner and triangle stores and
// the result data are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_ortho_clip_near_far_top import aoc_pkg::*; #(
  parameter int WORK_TRIANGLES = 16,
  parameter int FRACTION_BITS  = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  aoc_in_if.sink     in_chan,
  aoc_out_if.source  out_chan
);

  localparam int IDX_W  = $clog2(WORK_TRIANGLES);
  localparam int CNT_W  = $clog2(WORK_TRIANGLES + 1);
  localparam int Q_W    = FRACTION_BITS + 1;       // crossing fraction, up to 1.0
  localparam int MAG_W  = COORD_W + 1;             // magnitude of a 33-bit difference
  localparam int PROD_W = MAG_W + Q_W;
  localparam int DCNT_W = $clog2(Q_W + 1);

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SEED  = 5'd1;   // gather box triangle corners
  localparam logic [4:0] S_SEEDW = 5'd2;   // write it as work triangle 0
  localparam logic [4:0] S_CHK   = 5'd3;   // next work triangle for this plane
  localparam logic [4:0] S_RD    = 5'd4;
  localparam logic [4:0] S_LD    = 5'd5;
  localparam logic [4:0] S_SORT  = 5'd6;   // inside test, reorder, classify
  localparam logic [4:0] S_SPLRD = 5'd7;   // split: read the neighbor row
  localparam logic [4:0] S_SPLCP = 5'd8;   // split: move neighbor to list end
  localparam logic [4:0] S_XINIT = 5'd9;   // crossing: set up divide
  localparam logic [4:0] S_XDIV  = 5'd10;  // crossing: one quotient bit
  localparam logic [4:0] S_XDIF  = 5'd11;  // crossing: component difference
  localparam logic [4:0] S_XMUL  = 5'd12;  // crossing: scale by fraction
  localparam logic [4:0] S_XADD  = 5'd13;  // crossing: offset from start point
  localparam logic [4:0] S_WR1   = 5'd14;  // one inside: shortened triangle
  localparam logic [4:0] S_WRA   = 5'd15;  // two inside: second half
  localparam logic [4:0] S_WRB   = 5'd16;  // two inside: first half
  localparam logic [4:0] S_ZCHK  = 5'd17;  // depth scan over the work list
  localparam logic [4:0] S_ZRD   = 5'd18;
  localparam logic [4:0] S_ZLD   = 5'd19;
  localparam logic [4:0] S_ZCMP  = 5'd20;
  localparam logic [4:0] S_DONE  = 5'd21;

  logic [4:0]                state_r;

  // operand stores
  vert_t                     corner_r [8];
  coord_t                    win_r [CLIP_PLANES];

  // work list control
  logic [WORK_TRIANGLES-1:0] flags_r;        // dropped flag per work triangle
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          i_r;
  logic [1:0]                plane_r;
  logic [3:0]                box_r;          // box triangle 0..11
  logic [1:0]                vk_r;           // vertex / component step
  logic [1:0]                n_r;            // inside vertex count
  logic                      job_r;          // which of the two crossings

  tri_t                      tri_r;
  vert_t                     p0_r;
  vert_t                     p1_r;

  // shared crossing unit
  logic [MAG_W:0]            rem_r;
  logic [MAG_W-1:0]          den_r;
  logic [Q_W-1:0]            q_r;
  logic [DCNT_W-1:0]         dcnt_r;
  logic [MAG_W-1:0]          dmag_r;
  logic                      dneg_r;
  logic [PROD_W-1:0]         prod_r;

  coord_t                    min_r;
  coord_t                    max_r;
  logic                      any_r;

  logic                      out_valid_r;
  coord_t                    out_near_r;
  coord_t                    out_far_r;
  logic                      out_empty_r;

  // RAM hookup
  logic                      wr_en_w;
  logic [IDX_W-1:0]          wr_addr_w;
  tri_t                      wr_data_w;
  logic [IDX_W-1:0]          rd_addr_w;
  tri_t                      rd_data_w;

  logic [CNT_W-1:0]          ip1_w;
  logic [1:0]                ax_w;
  coord_t                    edge_w;
  logic [2:0]                in_w;
  logic [2:0]                inf_w;
  tri_t                      srt_w;
  logic [1:0]                n_w;
  vert_t                     a_w;
  vert_t                     b_w;
  logic [MAG_W-1:0]          hit_w;
  logic [MAG_W-1:0]          dd_w;
  logic [MAG_W-1:0]          diff_w;
  logic                      ge_w;
  logic [MAG_W:0]            rsub_w;
  logic [MAG_W:0]            pfx_w;
  logic [MAG_W+1:0]          a35_w;
  logic [MAG_W+1:0]          sum_w;
  logic [5:0]                seed_idx_w;
  coord_t                    z_w;

  aoc_ram #(
    .WIDTH (TRI_W),
    .DEPTH (WORK_TRIANGLES)
  ) u_tri_ram (
    .clk   (clk),
    .we    (wr_en_w),
    .waddr (wr_addr_w),
    .wdata (wr_data_w),
    .raddr (rd_addr_w),
    .rdata (rd_data_w)
  );

  assign in_chan.ready             = (state_r == S_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.near_z           = out_near_r;
  assign out_chan.far_z            = out_far_r;
  assign out_chan.nothing_survived = out_empty_r;

  assign ip1_w  = i_r + 1'b1;
  // planes 0,1 test x; planes 2,3 test y
  assign ax_w   = {1'b0, plane_r[1]};
  assign edge_w = win_r[plane_r];

  // Inside test and reorder: inside vertices move to the front.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (plane_r[0]) begin
        in_w[k] = $signed(tri_r[k][ax_w]) < edge_w;
      end else begin
        in_w[k] = $signed(tri_r[k][ax_w]) > edge_w;
      end
    end
    srt_w = tri_r;
    inf_w = in_w;
    if (inf_w[1] && !inf_w[0]) begin
      {srt_w[0], srt_w[1]} = {srt_w[1], srt_w[0]};
      inf_w[0] = 1'b1;
      inf_w[1] = 1'b0;
    end
    if (inf_w[2] && !inf_w[1]) begin
      {srt_w[1], srt_w[2]} = {srt_w[2], srt_w[1]};
      inf_w[1] = 1'b1;
      inf_w[2] = 1'b0;
    end
    if (inf_w[1] && !inf_w[0]) begin
      {srt_w[0], srt_w[1]} = {srt_w[1], srt_w[0]};
      inf_w[0] = 1'b1;
      inf_w[1] = 1'b0;
    end
    n_w = {1'b0, in_w[0]} + {1'b0, in_w[1]} + {1'b0, in_w[2]};
  end

  // Crossing end points. One inside: start at the inside vertex 0 toward
  // vertices 1 and 2. Two inside: start at outside vertex 2 toward 0 and 1.
  always_comb begin
    a_w = (n_r == 2'd1) ? tri_r[0] : tri_r[2];
    if (!job_r) begin
      b_w = (n_r == 2'd1) ? tri_r[1] : tri_r[0];
    end else begin
      b_w = (n_r == 2'd1) ? tri_r[2] : tri_r[1];
    end
  end

  // divide set-up: edge - a and b - a on the plane axis
  assign hit_w = {edge_w[COORD_W-1], edge_w}
               - {a_w[ax_w][COORD_W-1], a_w[ax_w]};
  assign dd_w  = {b_w[ax_w][COORD_W-1], b_w[ax_w]}
               - {a_w[ax_w][COORD_W-1], a_w[ax_w]};
  // per-component difference for the scale step
  assign diff_w = {b_w[vk_r][COORD_W-1], b_w[vk_r]}
                - {a_w[vk_r][COORD_W-1], a_w[vk_r]};

  // restoring divide step; quotient never exceeds 1.0 since |hit| <= |den|
  assign ge_w   = rem_r >= {1'b0, den_r};
  assign rsub_w = ge_w ? (rem_r - {1'b0, den_r}) : rem_r;

  // a +/- (|d| * t) >> FRACTION_BITS
  assign pfx_w = prod_r[PROD_W-1:FRACTION_BITS];
  assign a35_w = {{2{a_w[vk_r][COORD_W-1]}}, a_w[vk_r][COORD_W-1], a_w[vk_r]};
  assign sum_w = dneg_r ? (a35_w - {1'b0, pfx_w}) : (a35_w + {1'b0, pfx_w});

  assign seed_idx_w = 6'(box_r) * 6'd3 + 6'(vk_r);
  assign z_w        = $signed(tri_r[vk_r][2]);

  // work RAM ports
  always_comb begin
    wr_en_w   = 1'b0;
    wr_addr_w = i_r[IDX_W-1:0];
    wr_data_w = tri_r;
    rd_addr_w = i_r[IDX_W-1:0];
    case (state_r)
      S_SEEDW: begin
        wr_en_w   = 1'b1;
        wr_addr_w = '0;
      end
      S_SPLRD: begin
        rd_addr_w = ip1_w[IDX_W-1:0];
      end
      S_SPLCP: begin
        wr_en_w   = 1'b1;
        wr_addr_w = count_r[IDX_W-1:0];
        wr_data_w = rd_data_w;
      end
      S_WR1: begin
        wr_en_w      = 1'b1;
        wr_data_w[0] = tri_r[0];
        wr_data_w[1] = p1_r;
        wr_data_w[2] = p0_r;
      end
      S_WRA: begin
        wr_en_w      = 1'b1;
        wr_addr_w    = ip1_w[IDX_W-1:0];
        wr_data_w[0] = tri_r[0];
        wr_data_w[1] = tri_r[1];
        wr_data_w[2] = p0_r;
      end
      S_WRB: begin
        wr_en_w      = 1'b1;
        wr_data_w[0] = tri_r[1];
        wr_data_w[1] = p0_r;
        wr_data_w[2] = p1_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flags_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      min_r       <= COORD_MAX;
      max_r       <= COORD_MIN;
      any_r       <= 1'b0;
    end else begin
      // S_DONE handles the result register itself
      if (out_valid_r && out_chan.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            corner_r[in_chan.corner_index] <=
              {in_chan.corner_z, in_chan.corner_y, in_chan.corner_x};
            if (in_chan.corner_index == 3'd7) begin
              win_r[0] <= in_chan.window_min_x;
              win_r[1] <= in_chan.window_max_x;
              win_r[2] <= in_chan.window_min_y;
              win_r[3] <= in_chan.window_max_y;
              min_r    <= COORD_MAX;
              max_r    <= COORD_MIN;
              any_r    <= 1'b0;
              box_r    <= '0;
              vk_r     <= '0;
              state_r  <= S_SEED;
            end
          end
        end
        S_SEED: begin
          tri_r[vk_r] <= corner_r[BOX_CORNER[seed_idx_w]];
          if (vk_r == 2'd2) begin
            state_r <= S_SEEDW;
          end else begin
            vk_r <= vk_r + 1'b1;
          end
        end
        S_SEEDW: begin
          flags_r[0] <= 1'b0;
          count_r    <= CNT_W'(1);
          i_r        <= '0;
          plane_r    <= '0;
          state_r    <= S_CHK;
        end
        S_CHK: begin
          if (i_r < count_r) begin
            if (flags_r[i_r[IDX_W-1:0]]) begin
              i_r <= ip1_w;
            end else begin
              state_r <= S_RD;
            end
          end else begin
            i_r <= '0;
            if (plane_r == 2'(CLIP_PLANES - 1)) begin
              state_r <= S_ZCHK;
            end else begin
              plane_r <= plane_r + 1'b1;
            end
          end
        end
        S_RD: begin
          state_r <= S_LD;
        end
        S_LD: begin
          tri_r   <= rd_data_w;
          state_r <= S_SORT;
        end
        S_SORT: begin
          tri_r <= srt_w;
          n_r   <= n_w;
          job_r <= 1'b0;
          case (n_w)
            2'd0: begin
              flags_r[i_r[IDX_W-1:0]] <= 1'b1;
              i_r     <= ip1_w;
              state_r <= S_CHK;
            end
            2'd1: begin
              state_r <= S_XINIT;
            end
            2'd2: begin
              if (count_r < CNT_W'(WORK_TRIANGLES)) begin
                state_r <= S_SPLRD;
              end else begin
                // list full: keep the triangle as it is
                i_r     <= ip1_w;
                state_r <= S_CHK;
              end
            end
            default: begin
              i_r     <= ip1_w;
              state_r <= S_CHK;
            end
          endcase
        end
        S_SPLRD: begin
          state_r <= S_SPLCP;
        end
        S_SPLCP: begin
          flags_r[count_r[IDX_W-1:0]] <= flags_r[ip1_w[IDX_W-1:0]];
          state_r <= S_XINIT;
        end
        S_XINIT: begin
          rem_r   <= {1'b0, (hit_w[MAG_W-1] ? (~hit_w + 1'b1) : hit_w)};
          den_r   <= dd_w[MAG_W-1] ? (~dd_w + 1'b1) : dd_w;
          q_r     <= '0;
          dcnt_r  <= '0;
          state_r <= S_XDIV;
        end
        S_XDIV: begin
          q_r    <= {q_r[Q_W-2:0], ge_w};
          rem_r  <= {rsub_w[MAG_W-1:0], 1'b0};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCNT_W'(Q_W - 1)) begin
            vk_r    <= '0;
            state_r <= S_XDIF;
          end
        end
        S_XDIF: begin
          dneg_r  <= diff_w[MAG_W-1];
          dmag_r  <= diff_w[MAG_W-1] ? (~diff_w + 1'b1) : diff_w;
          state_r <= S_XMUL;
        end
        S_XMUL: begin
          prod_r  <= dmag_r * q_r;
          state_r <= S_XADD;
        end
        S_XADD: begin
          if (job_r) begin
            p1_r[vk_r] <= sum_w[COORD_W-1:0];
          end else begin
            p0_r[vk_r] <= sum_w[COORD_W-1:0];
          end
          if (vk_r == 2'd2) begin
            if (!job_r) begin
              job_r   <= 1'b1;
              state_r <= S_XINIT;
            end else if (n_r == 2'd1) begin
              state_r <= S_WR1;
            end else begin
              state_r <= S_WRA;
            end
          end else begin
            vk_r    <= vk_r + 1'b1;
            state_r <= S_XDIF;
          end
        end
        S_WR1: begin
          i_r     <= ip1_w;
          state_r <= S_CHK;
        end
        S_WRA: begin
          state_r <= S_WRB;
        end
        S_WRB: begin
          // both halves live
          flags_r <= flags_r
                   & ~((WORK_TRIANGLES'(1) << i_r[IDX_W-1:0])
                     | (WORK_TRIANGLES'(1) << ip1_w[IDX_W-1:0]));
          count_r <= count_r + 1'b1;
          // the new half is not tested again against this plane
          i_r     <= i_r + CNT_W'(2);
          state_r <= S_CHK;
        end
        S_ZCHK: begin
          if (i_r < count_r) begin
            if (flags_r[i_r[IDX_W-1:0]]) begin
              i_r <= ip1_w;
            end else begin
              state_r <= S_ZRD;
            end
          end else if (box_r == 4'(BOX_TRIS - 1)) begin
            state_r <= S_DONE;
          end else begin
            box_r   <= box_r + 1'b1;
            vk_r    <= '0;
            state_r <= S_SEED;
          end
        end
        S_ZRD: begin
          state_r <= S_ZLD;
        end
        S_ZLD: begin
          tri_r   <= rd_data_w;
          vk_r    <= '0;
          state_r <= S_ZCMP;
        end
        S_ZCMP: begin
          any_r <= 1'b1;
          if (z_w < min_r) begin
            min_r <= z_w;
          end
          if (z_w > max_r) begin
            max_r <= z_w;
          end
          if (vk_r == 2'd2) begin
            i_r     <= ip1_w;
            state_r <= S_ZCHK;
          end else begin
            vk_r <= vk_r + 1'b1;
          end
        end
        S_DONE: begin
          // hold until the previous result has been taken
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_near_r  <= min_r;
            out_far_r   <= max_r;
            out_empty_r <= !any_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> dv/aabb_ortho_clip_near_far_top_test.sv
// ----------------------------------------------------------------------------
// aabb_ortho_clip_near_far_top_test: near/far clip depth testbench
// Sends box corners and clip windows, predicts the clipped near/far depth of
// every box, and compares each result request against the prediction.
// ----------------------------------------------------------------------------
module aabb_ortho_clip_near_far_top_test;
  import aoc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORK_TRIS = 16;
  localparam int FRAC_BITS = 16;
  localparam longint CYCLE_LIMIT = 64'd20_000_000;

  typedef struct packed {
    coord_t near_z;
    coord_t far_z;
    logic   empty;
  } depth_t;

  logic clk;
  logic rst_n;
  aoc_in_if  in_chan ();
  aoc_out_if out_chan ();

  aabb_ortho_clip_near_far_top #(
    .WORK_TRIANGLES(WORK_TRIS),
    .FRACTION_BITS (FRAC_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // predictor state
  coord_t corner_q [8][3];
  coord_t tri_q [WORK_TRIS][3][3];
  bit     dropped_q [WORK_TRIS];
  int     tri_cnt;
  coord_t win_q [4];

  depth_t expected_depths [$];
  int     errors;
  longint cycles;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_cycles;     // long receiver hold-off, counted by its own process

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint unsigned abs64(longint d);
    return d < 0 ? longint'(0) - d : d;
  endfunction

  // fraction from a to b where axis ax meets the clip line, truncated, at most one
  function automatic longint unsigned edge_fraction(coord_t a[3], coord_t b[3], int ax,
                                                    coord_t lim);
    longint hit, den;
    longint unsigned t;
    hit = longint'(lim) - longint'(a[ax]);
    den = longint'(b[ax]) - longint'(a[ax]);
    if (den == 0) return 0;
    if ((hit < 0) != (den < 0)) return 0;
    t = (abs64(hit) << FRAC_BITS) / abs64(den);
    if (t > (64'd1 << FRAC_BITS)) t = 64'd1 << FRAC_BITS;
    return t;
  endfunction

  function automatic void lerp_point(coord_t a[3], coord_t b[3], longint unsigned t,
                                     output coord_t r[3]);
    longint d;
    longint unsigned p;
    for (int k = 0; k < 3; k++) begin
      d = longint'(b[k]) - longint'(a[k]);
      p = (abs64(d) * t) >> FRAC_BITS;
      r[k] = d < 0 ? coord_t'(longint'(a[k]) - longint'(p))
                   : coord_t'(longint'(a[k]) + longint'(p));
    end
  endfunction

  function automatic void swap_vertex(int i, int j, int m);
    coord_t tmp[3];
    tmp = tri_q[i][j];
    tri_q[i][j] = tri_q[i][m];
    tri_q[i][m] = tmp;
  endfunction

  function automatic void clip_against(int plane);
    int ax;
    coord_t lim;
    bit vin[3];
    int n;
    coord_t p01[3], p02[3], p20[3], p21[3], v0[3], v1[3];
    int nx;
    ax = plane < 2 ? 0 : 1;
    lim = win_q[plane];
    for (int i = 0; i < tri_cnt && i < WORK_TRIS; i++) begin
      if (dropped_q[i]) continue;
      n = 0;
      for (int k = 0; k < 3; k++) begin
        vin[k] = plane[0] ? (tri_q[i][k][ax] < lim) : (tri_q[i][k][ax] > lim);
        n += vin[k];
      end
      if (vin[1] && !vin[0]) begin swap_vertex(i, 0, 1); vin[0] = 1; vin[1] = 0; end
      if (vin[2] && !vin[1]) begin swap_vertex(i, 1, 2); vin[1] = 1; vin[2] = 0; end
      if (vin[1] && !vin[0]) begin swap_vertex(i, 0, 1); vin[0] = 1; vin[1] = 0; end
      if (n == 0) begin
        dropped_q[i] = 1;
      end else if (n == 1) begin
        lerp_point(tri_q[i][0], tri_q[i][1],
                   edge_fraction(tri_q[i][0], tri_q[i][1], ax, lim), p01);
        lerp_point(tri_q[i][0], tri_q[i][2],
                   edge_fraction(tri_q[i][0], tri_q[i][2], ax, lim), p02);
        tri_q[i][1] = p02;
        tri_q[i][2] = p01;
      end else if (n == 2 && tri_cnt < WORK_TRIS) begin
        nx = i + 1;
        tri_q[tri_cnt] = tri_q[nx];
        dropped_q[tri_cnt] = dropped_q[nx];
        dropped_q[i] = 0;
        dropped_q[nx] = 0;
        lerp_point(tri_q[i][2], tri_q[i][0],
                   edge_fraction(tri_q[i][2], tri_q[i][0], ax, lim), p20);
        lerp_point(tri_q[i][2], tri_q[i][1],
                   edge_fraction(tri_q[i][2], tri_q[i][1], ax, lim), p21);
        v0 = tri_q[i][0];
        v1 = tri_q[i][1];
        tri_q[nx][0] = v0;
        tri_q[nx][1] = v1;
        tri_q[nx][2] = p20;
        tri_q[i][0] = v1;
        tri_q[i][1] = p20;
        tri_q[i][2] = p21;
        tri_cnt++;
        i++;
      end
    end
  endfunction

  function automatic void predict_depth(corner_idx_t idx, coord_t x, coord_t y, coord_t z,
                                        coord_t wx0, coord_t wx1, coord_t wy0, coord_t wy1);
    depth_t d;
    bit any;
    coord_t zv;
    corner_q[idx][0] = x;
    corner_q[idx][1] = y;
    corner_q[idx][2] = z;
    if (idx != 3'd7) return;
    win_q[0] = wx0; win_q[1] = wx1; win_q[2] = wy0; win_q[3] = wy1;
    d.near_z = COORD_MAX;
    d.far_z = COORD_MIN;
    any = 0;
    for (int t = 0; t < BOX_TRIS; t++) begin
      for (int k = 0; k < 3; k++) tri_q[0][k] = corner_q[BOX_CORNER[t*3+k]];
      dropped_q[0] = 0;
      tri_cnt = 1;
      for (int p = 0; p < CLIP_PLANES; p++) clip_against(p);
      for (int i = 0; i < tri_cnt && i < WORK_TRIS; i++) begin
        if (dropped_q[i]) continue;
        any = 1;
        for (int k = 0; k < 3; k++) begin
          zv = tri_q[i][k][2];
          if (zv < d.near_z) d.near_z = zv;
          if (zv > d.far_z) d.far_z = zv;
        end
      end
    end
    d.empty = !any;
    expected_depths.push_back(d);
  endfunction

  // --------------------------------------------------------------------------
  // Driving and checking
  // --------------------------------------------------------------------------
  // valid stays up after a request until the next one or an idle cycle
  task automatic send_corner(corner_idx_t idx, coord_t x, coord_t y, coord_t z,
                             coord_t wx0, coord_t wx1, coord_t wy0, coord_t wy1);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.corner_index <= idx;
    in_chan.corner_x     <= x;
    in_chan.corner_y     <= y;
    in_chan.corner_z     <= z;
    in_chan.window_min_x <= wx0;
    in_chan.window_max_x <= wx1;
    in_chan.window_min_y <= wy0;
    in_chan.window_max_y <= wy1;
    do @(posedge clk); while (!in_chan.ready);
    predict_depth(idx, x, y, z, wx0, wx1, wy0, wy1);
    @(negedge clk);
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    depth_t d;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_depths.size() == 0) begin
        $error("unexpected result request near_z=%0d far_z=%0d", out_chan.near_z,
               out_chan.far_z);
        errors++;
      end else begin
        d = expected_depths.pop_front();
        if (out_chan.near_z !== d.near_z) begin
          $error("near_z: expected %0d, actual %0d", d.near_z, out_chan.near_z);
          errors++;
        end
        if (out_chan.far_z !== d.far_z) begin
          $error("far_z: expected %0d, actual %0d", d.far_z, out_chan.far_z);
          errors++;
        end
        if (out_chan.nothing_survived !== d.empty) begin
          $error("nothing_survived: expected %0b, actual %0b", d.empty,
                 out_chan.nothing_survived);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (expected_depths.size() != 0) @(negedge clk);
  endtask

  // random Q16.16 value, mostly moderate, sometimes anywhere in range
  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0: return coord_t'($urandom());
      1: return $urandom_range(1) ? COORD_MAX : COORD_MIN;
      2: return coord_t'($signed($urandom_range(2000)) - 1000) <<< 16;
      default: return coord_t'($signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000);
    endcase
  endfunction

  // a whole box: eight corners, each sent with a random window
  task automatic send_box(bit bounded);
    coord_t cx, cy, cz, ex, ey, ez, wx0, wx1, wy0, wy1;
    cx = rand_coord() >>> 4; cy = rand_coord() >>> 4; cz = rand_coord() >>> 2;
    ex = coord_t'($urandom_range(32'h0040_0000));
    ey = coord_t'($urandom_range(32'h0040_0000));
    ez = coord_t'($urandom_range(32'h0040_0000));
    for (int c = 0; c < 8; c++) begin
      if (!bounded) begin
        cx = rand_coord(); cy = rand_coord(); cz = rand_coord();
      end
      wx0 = rand_coord() >>> 4; wx1 = wx0 + coord_t'($urandom_range(32'h0060_0000));
      wy0 = rand_coord() >>> 4; wy1 = wy0 + coord_t'($urandom_range(32'h0060_0000));
      if ($urandom_range(15) == 0) begin
        wx0 = rand_coord(); wx1 = rand_coord(); wy0 = rand_coord(); wy1 = rand_coord();
      end
      if (bounded)
        send_corner(corner_idx_t'(c), c[0] ? cx + ex : cx - ex, c[1] ? cy + ey : cy - ey,
                    c[2] ? cz + ez : cz - ez, wx0, wx1, wy0, wy1);
      else
        send_corner(corner_idx_t'(c), cx, cy, cz, wx0, wx1, wy0, wy1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    coord_t w;
    w = 32'sh0001_0000;
    // window around a small box: every case of inside/outside appears
    for (int c = 0; c < 8; c++)
      send_corner(corner_idx_t'(c), c[0] ? 2*w : -2*w, c[1] ? w : -w, c[2] ? 3*w : -3*w,
                  -w, w, -w/2, 3*w);
    // inverted window: empty result
    send_corner(3'd7, w, w, w, w, -w, -w, w);
    // extremes of all fields, window fully open
    send_corner(3'd0, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 0);
    send_corner(3'd7, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
                COORD_MIN, COORD_MAX);
    // box fully inside a large window
    for (int c = 0; c < 8; c++)
      send_corner(corner_idx_t'(c), c[0] ? w : 0, c[1] ? w : 0, c[2] ? -w : COORD_MAX,
                  COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    // window edges on corners exactly: strict tests drop them
    send_corner(3'd7, w, w, w, 0, w, 0, w);
    drain();
  endtask

  task automatic test_random(int boxes, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int b = 0; b < boxes; b++) begin
      if ($urandom_range(7) == 0) begin
        // stray single corner update without a full box
        send_corner(corner_idx_t'($urandom_range(7)), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
      send_box($urandom_range(4) != 0);
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 8000;
    send_box(1'b1);
    send_box(1'b1);
    send_box(1'b1);
    drain();
    // sender waits for all results before the next box
    send_box(1'b1);
    drain();
    send_box(1'b0);
    drain();
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.corner_index = '0;
    in_chan.corner_x = '0;
    in_chan.corner_y = '0;
    in_chan.corner_z = '0;
    in_chan.window_min_x = '0;
    in_chan.window_max_x = '0;
    in_chan.window_min_y = '0;
    in_chan.window_max_y = '0;
    out_chan.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(35, 0, 0);
    test_random(35, 81, 0);
    test_random(35, 0, 81);
    test_random(25, 37, 37);
    test_backpressure();

    repeat (3000) @(negedge clk);
    if (errors == 0 && expected_depths.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/aoc_pkg.sv
rtl/aoc_if.sv
rtl/aoc_ram.sv
rtl/aabb_ortho_clip_near_far_top.sv
dv/aabb_ortho_clip_near_far_top_test.sv
